/* hdl/md5_stream_hasher_top_defines.svh */
// Assertion macros for the MD5 stream hasher checker.
`ifndef MD5_STREAM_HASHER_TOP_DEFINES_SVH
`define MD5_STREAM_HASHER_TOP_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define MD5_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* hdl/md5_pkg.sv */
// Package with MD5 word types, round constants and helper functions.
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        logic [63:0] digest_half;
        logic        last_half;
    } out_word_t;

    // Command from front to back: absorb a full block, or finish with a padded tail.
    typedef enum logic [1:0] {
        CMD_BLOCK = 2'b01,
        CMD_FINAL = 2'b10
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t    kind;
        logic [511:0] block;
        logic [5:0]   tail_len;
        logic [60:0]  byte_count;
    } cmd_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    function automatic logic [31:0] sine_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] shift_amt(input logic [3:0] idx);
        logic [4:0] r;
        case (idx)
            4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
            4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
            4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
            4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
        endcase
        return r;
    endfunction

endpackage

/* hdl/md5_stream_hasher_top.sv */
// Top level of the MD5 stream hasher.
//  channel | dir | payload              | handshake
//  in      | in  | md5_pkg::in_word_t   | in_valid / in_stall
//  out     | out | md5_pkg::out_word_t  | out_valid / out_stall
// A word is taken in the cycle it is offered unless the collector holds an unsent command.
// Each 64-byte block passes through setup, 64 rounds and the chaining add;
// the engine's single round unit takes a new block only when it is done with the last.
// A final word adds one or two blocks, then two digest words, the second marked last.
// Reset loads the initial chaining words and clears counts; no clearing pass.
// The two-entry queue lets the collector run ahead while the engine or out stalls.
module md5_stream_hasher_top (
    input  logic               clk,
    input  logic               rst_n,
    input  md5_pkg::in_word_t  in_word,
    input  logic               in_valid,
    output logic               in_stall,
    output md5_pkg::out_word_t out_word,
    output logic               out_valid,
    input  logic               out_stall
);

    md5_pkg::cmd_t f_cmd, q_cmd;
    logic f_valid, f_stall, q_valid, q_stall;

    md5_front u_front (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .cmd(f_cmd), .cmd_valid(f_valid), .cmd_stall(f_stall)
    );

    md5_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_cmd(f_cmd), .wr_valid(f_valid),
        .wr_stall(f_stall), .rd_cmd(q_cmd), .rd_valid(q_valid), .rd_stall(q_stall)
    );

    md5_engine u_engine (
        .clk(clk), .rst_n(rst_n), .cmd(q_cmd), .cmd_valid(q_valid),
        .cmd_stall(q_stall), .out_word(out_word), .out_valid(out_valid),
        .out_stall(out_stall)
    );

endmodule

/* hdl/md5_front.sv */
// Byte collector: packs bytes into blocks and issues block and final commands.
module md5_front (
    input  logic            clk,
    input  logic            rst_n,
    input  md5_pkg::in_word_t in_word,
    input  logic            in_valid,
    output logic            in_stall,
    output md5_pkg::cmd_t   cmd,
    output logic            cmd_valid,
    input  logic            cmd_stall
);

    logic [511:0] buf_reg, buf_next;
    logic [60:0]  count_reg, count_next;
    logic         pend_reg, pend_next;
    logic         fin_reg, fin_next;
    md5_pkg::cmd_t cmd_reg, cmd_next;
    logic [5:0]   pos;
    logic         take;

    assign in_stall  = pend_reg;
    assign cmd_valid = pend_reg;
    assign cmd       = cmd_reg;
    assign take      = in_valid && !pend_reg;
    assign pos       = count_reg[5:0];

    always_comb
    begin
        buf_next   = buf_reg;
        count_next = count_reg;
        pend_next  = pend_reg && cmd_stall;
        cmd_next   = cmd_reg;
        if (take)
        begin
            if (in_word.byte_valid)
            begin
                buf_next[{pos, 3'b000} +: 8] = in_word.data_byte;
                count_next = count_reg + 61'd1;
                if (pos == 6'd63)
                begin
                    cmd_next.kind  = md5_pkg::CMD_BLOCK;
                    cmd_next.block = buf_next;
                    pend_next      = 1'b1;
                end
            end
            if (in_word.end_of_message)
            begin
                // final command follows any full block in the same word
                cmd_next.tail_len   = count_next[5:0];
                cmd_next.byte_count = count_next;
                if (!(in_word.byte_valid && pos == 6'd63))
                begin
                    cmd_next.kind  = md5_pkg::CMD_FINAL;
                    cmd_next.block = buf_next;
                    pend_next      = 1'b1;
                end
                count_next = '0;
            end
        end
        // second command for a word that both fills a block and ends the message
        if (pend_reg && !cmd_stall && fin_reg)
        begin
            pend_next     = 1'b1;
            cmd_next.kind = md5_pkg::CMD_FINAL;
        end
    end

    always_comb
    begin
        fin_next = fin_reg;
        if (take)
            fin_next = in_word.byte_valid && pos == 6'd63 && in_word.end_of_message;
        else if (pend_reg && !cmd_stall && fin_reg)
            fin_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        cmd_reg <= cmd_next;
    end

endmodule

/* hdl/md5_queue.sv */
// Two-entry command queue between collector and compression engine.
module md5_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  md5_pkg::cmd_t wr_cmd,
    input  logic          wr_valid,
    output logic          wr_stall,
    output md5_pkg::cmd_t rd_cmd,
    output logic          rd_valid,
    input  logic          rd_stall
);

    md5_pkg::cmd_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_stall = cnt_reg == 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_cmd   = mem_reg[rptr_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wr_cmd;
    end

endmodule

/* hdl/md5_engine.sv */
// Compression engine: one MD5 round per cycle, padding and digest output.
module md5_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  md5_pkg::cmd_t     cmd,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    output md5_pkg::out_word_t out_word,
    output logic              out_valid,
    input  logic              out_stall
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ROUND = 5'b00010,
        S_ADD   = 5'b00100,
        S_OUT0  = 5'b01000,
        S_OUT1  = 5'b10000
    } state_t;

    state_t      state_reg, state_next;
    logic [511:0] blk_reg, blk_next;
    logic [31:0] h_reg [4];
    logic [31:0] h_next [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        fin_reg, fin_next;   // final block of message
    logic        spill_reg, spill_next; // second padded block still owed
    logic [60:0] cnt_reg, cnt_next;
    logic        take;

    logic [31:0] f, sum, rot, w;
    logic [3:0]  g;
    logic [4:0]  r;
    logic [1:0]  ph;
    logic [511:0] pad, lenblk;

    assign take      = state_reg == S_IDLE && cmd_valid;
    assign cmd_stall = !(state_reg == S_IDLE);
    assign out_valid = state_reg == S_OUT0 || state_reg == S_OUT1;
    assign out_word  = state_reg == S_OUT1 ? {h_reg[3], h_reg[2], 1'b1}
                                           : {h_reg[1], h_reg[0], 1'b0};

    assign ph = rnd_reg[5:4];
    always_comb
    begin
        case (ph)
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = rnd_reg[3:0];
            end
            2'd1:
            begin
                f = (b_reg & d_reg) | (c_reg & ~d_reg);
                g = 4'(5 * rnd_reg + 1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(3 * rnd_reg + 5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(7 * rnd_reg);
            end
        endcase
        r   = md5_pkg::shift_amt({ph, rnd_reg[1:0]});
        w   = blk_reg[{g, 5'b00000} +: 32];
        sum = a_reg + f + w + md5_pkg::sine_k(rnd_reg);
        rot = (sum << r) | (sum >> (6'd32 - {1'b0, r}));
    end

    // padded tail: 0x80 after tail bytes, zeros above
    always_comb
    begin
        pad = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (i < cmd.tail_len)
                pad[i*8 +: 8] = cmd.block[i*8 +: 8];
            else if (i == cmd.tail_len)
                pad[i*8 +: 8] = 8'h80;
        end
        lenblk = '0;
        lenblk[511:448] = {cnt_reg, 3'b000};
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        spill_next = spill_reg;
        cnt_next   = cnt_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        for (int i = 0; i < 4; i++)
            h_next[i] = h_reg[i];
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    rnd_next   = '0;
                    a_next = h_reg[0]; b_next = h_reg[1];
                    c_next = h_reg[2]; d_next = h_reg[3];
                    state_next = S_ROUND;
                    if (cmd.kind == md5_pkg::CMD_FINAL)
                    begin
                        cnt_next = cmd.byte_count;
                        if (cmd.tail_len >= 6'd56)
                        begin
                            blk_next   = pad;
                            fin_next   = 1'b0;
                            spill_next = 1'b1;
                        end
                        else
                        begin
                            blk_next = pad;
                            blk_next[511:448] = {cmd.byte_count, 3'b000};
                            fin_next   = 1'b1;
                            spill_next = 1'b0;
                        end
                    end
                    else
                    begin
                        blk_next   = cmd.block;
                        fin_next   = 1'b0;
                        spill_next = 1'b0;
                    end
                end
            end
            S_ROUND:
            begin
                a_next = d_reg;
                b_next = b_reg + rot;
                c_next = b_reg;
                d_next = c_reg;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                h_next[0] = h_reg[0] + a_reg;
                h_next[1] = h_reg[1] + b_reg;
                h_next[2] = h_reg[2] + c_reg;
                h_next[3] = h_reg[3] + d_reg;
                if (spill_reg)
                begin
                    blk_next   = lenblk;
                    spill_next = 1'b0;
                    fin_next   = 1'b1;
                    rnd_next   = '0;
                    a_next = h_next[0]; b_next = h_next[1];
                    c_next = h_next[2]; d_next = h_next[3];
                    state_next = S_ROUND;
                end
                else if (fin_reg)
                    state_next = S_OUT0;
                else
                    state_next = S_IDLE;
            end
            S_OUT0:
            begin
                if (!out_stall)
                    state_next = S_OUT1;
            end
            S_OUT1:
            begin
                if (!out_stall)
                begin
                    h_next[0] = md5_pkg::IV_A; h_next[1] = md5_pkg::IV_B;
                    h_next[2] = md5_pkg::IV_C; h_next[3] = md5_pkg::IV_D;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            spill_reg <= 1'b0;
            h_reg[0] <= md5_pkg::IV_A; h_reg[1] <= md5_pkg::IV_B;
            h_reg[2] <= md5_pkg::IV_C; h_reg[3] <= md5_pkg::IV_D;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            spill_reg <= spill_next;
            for (int i = 0; i < 4; i++)
                h_reg[i] <= h_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        cnt_reg <= cnt_next;
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
    end

endmodule

/* hdl/md5_checker.sv */
// Port-level checker for the MD5 stream hasher, bound to the top level.
`include "md5_stream_hasher_top_defines.svh"
module md5_checker (
    input logic               clk,
    input logic               rst_n,
    input md5_pkg::in_word_t  in_word,
    input logic               in_valid,
    input logic               in_stall,
    input md5_pkg::out_word_t out_word,
    input logic               out_valid,
    input logic               out_stall
);
    `MD5_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word), "out word dropped")
    `MD5_ASSERT_NEXT(a_pair, out_valid && !out_stall && !out_word.last_half, out_valid && out_word.last_half, "second half missing")
    `MD5_ASSERT_NEXT(a_gap, out_valid && !out_stall && out_word.last_half, !out_valid, "extra digest word")
endmodule

bind md5_stream_hasher_top md5_checker u_md5_checker (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
    .in_stall(in_stall), .out_word(out_word), .out_valid(out_valid),
    .out_stall(out_stall)
);

/* test/md5_stream_hasher_checker.sv */
`timescale 1ns / 1ps
// Checker for the MD5 stream hasher: digest predictor and scoreboard.
module md5_stream_hasher_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  md5_pkg::in_word_t  in_word,
    input  logic               in_valid,
    input  logic               in_stall,
    input  md5_pkg::out_word_t out_word,
    input  logic               out_valid,
    input  logic               out_stall,
    output int                 fail_count,
    output int                 digests_pending,
    output int                 digests_seen
);

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    logic [31:0] chain [4];
    logic [7:0]  blk [64];
    logic [60:0] byte_cnt;
    md5_pkg::out_word_t digest_q [$];

    task automatic chain_reset();
        chain[0] = md5_pkg::IV_A;
        chain[1] = md5_pkg::IV_B;
        chain[2] = md5_pkg::IV_C;
        chain[3] = md5_pkg::IV_D;
        byte_cnt = '0;
    endtask

    task automatic compress();
        logic [31:0] m [16];
        logic [31:0] a, b, c, d, f, t;
        int g, r;
        for (int i = 0; i < 16; i++)
            m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            r = ROT[(i / 16) * 4 + i % 4];
            t = a + f + m[g] + ROUND_K[i];
            t = (t << r) | (t >> (32 - r));
            a = d;
            d = c;
            c = b;
            b = b + t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endtask

    task automatic absorb(input md5_pkg::in_word_t w);
        int pos;
        logic [63:0] bits;
        if (w.byte_valid)
        begin
            pos = byte_cnt[5:0];
            blk[pos] = w.data_byte;
            byte_cnt = byte_cnt + 1;
            if (pos == 63)
                compress();
        end
        if (!w.end_of_message)
            return;
        pos = byte_cnt[5:0];
        blk[pos] = 8'h80;
        for (int i = pos + 1; i < 64; i++)
            blk[i] = 8'h00;
        if (pos >= 56)
        begin
            compress();
            for (int i = 0; i < 56; i++)
                blk[i] = 8'h00;
        end
        bits = {byte_cnt, 3'b000};
        for (int i = 0; i < 8; i++)
            blk[56+i] = bits[8*i +: 8];
        compress();
        digest_q.push_back('{digest_half: {chain[1], chain[0]}, last_half: 1'b0});
        digest_q.push_back('{digest_half: {chain[3], chain[2]}, last_half: 1'b1});
        chain_reset();
    endtask

    initial
    begin
        chain_reset();
        fail_count = 0;
        digests_seen = 0;
    end

    assign digests_pending = digest_q.size();

    always @(posedge clk)
    begin
        md5_pkg::out_word_t exp_w;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                absorb(in_word);
            if (out_valid && !out_stall)
            begin
                digests_seen++;
                if (digest_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected word: %h last %b",
                                 out_word.digest_half, out_word.last_half);
                end
                else
                begin
                    exp_w = digest_q.pop_front();
                    if (exp_w !== out_word)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %h/%b got %h/%b",
                                     exp_w.digest_half, exp_w.last_half,
                                     out_word.digest_half, out_word.last_half);
                    end
                end
            end
        end
    end
endmodule

/* test/md5_stream_hasher_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the MD5 stream hasher: stimulus, clock, reset and verdict.
module md5_stream_hasher_top_tb;

    logic      clk;
    logic      rst_n;
    md5_pkg::in_word_t  in_word;
    logic      in_valid;
    logic      in_stall;
    md5_pkg::out_word_t out_word;
    logic      out_valid;
    logic      out_stall;
    int        fail_count;
    int        digests_pending;
    int        digests_seen;
    int        cycle_cnt;
    int        words_sent;
    bit        quiet_tail;

    md5_stream_hasher_top dut (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .out_word(out_word), .out_valid(out_valid),
        .out_stall(out_stall)
    );

    md5_stream_hasher_checker chk (
        .clk(clk), .rst_n(rst_n), .in_word(in_word), .in_valid(in_valid),
        .in_stall(in_stall), .out_word(out_word), .out_valid(out_valid),
        .out_stall(out_stall), .fail_count(fail_count),
        .digests_pending(digests_pending), .digests_seen(digests_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > 2000000)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 15) == 0)
            begin
                n = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send(input logic [7:0] b, input logic bv, input logic eom);
        int n;
        if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_word <= '{data_byte: b, byte_valid: bv, end_of_message: eom};
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_message(input int len, input int mode);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = (mode == 1) ? 8'hff : (mode == 2) ? 8'h00 : 8'($urandom);
            if ($urandom_range(0, 7) == 0)
                send(8'($urandom), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(0, 1))
                send(b, 1'b1, 1'b1);
            else
            begin
                send(b, 1'b1, 1'b0);
                if (i == len - 1)
                    send(8'($urandom), 1'b0, 1'b1);
            end
        end
        if (len == 0)
            send(8'($urandom), 1'b0, 1'b1);
    endtask

    initial
    begin
        int lens [10];
        lens = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
        in_word = '0;
        in_valid = 1'b0;
        quiet_tail = 1'b0;
        words_sent = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: empty, byte with end, all-ones/zeros, short padding edges
        send(8'h00, 1'b0, 1'b1);
        send(8'h61, 1'b1, 1'b1);
        send_message(3, 1);
        send_message(2, 2);
        send_message(4, 0);
        foreach (lens[i])
            send_message(lens[i], i % 3);
        // wait for every digest to drain
        in_valid <= 1'b0;
        while (digests_pending != 0)
            @(posedge clk);
        while (words_sent < 1650)
        begin
            if (words_sent > 1450)
                quiet_tail = 1'b1;
            case ($urandom_range(0, 5))
                0: send_message($urandom_range(54, 66), 0);
                1: send_message($urandom_range(0, 130), 0);
                default: send_message($urandom_range(0, 12), 0);
            endcase
        end
        in_valid <= 1'b0;
        while (digests_pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d input words with padding edge lengths and random messages;",
                 words_sent);
        $display("checked %0d digest words under random idling and stalls.", digests_seen);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
